>>> hw/rtl/qafs_pkg.sv
// Shared types and constants of the QUIC ACK frame scanner.
`default_nettype none
package qafs_pkg;

  // One payload byte word as it enters the scanner.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] payload_length;
    logic        last_byte;
  } item_t;

  // One per-packet result word.
  typedef struct packed {
    logic        is_quic;
    logic        long_header;
    logic [7:0]  ack_frames;
    logic [29:0] largest_acked;
  } result_t;

  // Scan phases.
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SCAN   = 2'd1;

  // Varint capture: waiting for the prefix byte.
  localparam logic [2:0] CAP_PREFIX = 3'd7;
  localparam logic [2:0] CAP_IDLE   = 3'd0;

  // Varint length prefixes (top two bits of the first byte).
  localparam logic [1:0] VI_LEN1 = 2'b00;
  localparam logic [1:0] VI_LEN2 = 2'b01;
  localparam logic [1:0] VI_LEN4 = 2'b10;

  // Header bits and versions.
  localparam int          HDR_LONG_BIT   = 7;
  localparam int          HDR_FIXED_BIT  = 6;
  localparam logic [31:0] VERSION_1      = 32'h0000_0001;
  localparam logic [31:0] VER_DRAFT_MASK = 32'hffff_ff00;
  localparam logic [31:0] VER_DRAFT      = 32'hff00_0000;

  // Frame types.
  localparam logic [7:0] FT_PADDING = 8'h00;
  localparam logic [7:0] FT_ACK     = 8'h02;
  localparam logic [7:0] FT_ACK_ECN = 8'h03;

  // Header layout and frame skips.
  localparam int SHORT_HDR_LEN = 1 + 8 + 4;
  localparam int DCID_LEN_POS  = 5;
  localparam int DCID_BASE     = 6;
  localparam int SCID_TAIL     = 1 + 2;
  localparam int VER_LAST_POS  = 4;
  localparam int ACK_SKIP      = 20;
  localparam int OTHER_SKIP    = 10;
  localparam int CAPTURE_REACH = 8;
  localparam int SCID_W        = 9;

endpackage
`default_nettype wire

>>> hw/rtl/qafs_in_stage.sv
// Input register of the scanner: holds one byte word until the core takes it.
`default_nettype none
module qafs_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic [11:0]      in_payload_length,
  input  logic             in_last_byte,
  input  logic             out_busy,
  output logic             item_vld,
  output logic             step,
  output qafs_pkg::item_t  item
);
  import qafs_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  take;

  // A word without an end marker never waits on the result side.
  assign step     = vld_r && (!item_r.last_byte || !out_busy);
  assign in_stall = vld_r && !step;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (step) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data_byte      <= in_data_byte;
      item_r.payload_length <= in_payload_length;
      item_r.last_byte      <= in_last_byte;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule
`default_nettype wire

>>> hw/rtl/qafs_core.sv
// Per-packet header parse, frame walk and ACK varint capture.
`default_nettype none
module qafs_core #(
  parameter int MAX_PAYLOAD = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  qafs_pkg::item_t   item,
  output logic              res_vld,
  output qafs_pkg::result_t res
);
  import qafs_pkg::*;

  localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
  localparam int CMP_W = (POS_W > 13) ? POS_W : 13;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_PAYLOAD);
  localparam logic [POS_W-1:0] MAX_P = POS_W'(MAX_PAYLOAD);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CMP_W-1:0]  nfo_r, nfo_nxt;
  logic [SCID_W-1:0] scid_r, scid_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [31:0]       ver_r, ver_nxt;
  logic [7:0]        ack_r, ack_nxt;
  logic [29:0]       la_r, la_nxt;
  logic [29:0]       var_r, var_nxt;
  logic [2:0]        cap_r, cap_nxt;

  always_comb begin
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] len_eff;
    logic [CMP_W-1:0] p_ext;
    logic [7:0]       b;
    logic             exam;
    logic             is_long;
    logic             ver_ok;
    logic             quic;

    pos_nxt   = pos_r;
    nfo_nxt   = nfo_r;
    scid_nxt  = scid_r;
    phase_nxt = phase_r;
    first_nxt = first_r;
    ver_nxt   = ver_r;
    ack_nxt   = ack_r;
    la_nxt    = la_r;
    var_nxt   = var_r;
    cap_nxt   = cap_r;
    is_long   = 1'b0;

    b       = item.data_byte;
    len_ext = CMP_W'(item.payload_length);
    len_eff = (len_ext > MAX_C) ? MAX_C : len_ext;
    p_ext   = CMP_W'(pos_r);
    exam    = step && (p_ext < len_eff);

    if (exam) begin
      if (p_ext == '0) begin
        first_nxt = b;
      end else if (p_ext <= CMP_W'(VER_LAST_POS)) begin
        ver_nxt = {ver_r[23:0], b};
      end
      is_long = first_nxt[HDR_LONG_BIT];

      if (phase_r == PH_HEADER) begin
        if (p_ext == '0 && !is_long) begin
          nfo_nxt   = CMP_W'(SHORT_HDR_LEN);
          phase_nxt = PH_SCAN;
        end else if (is_long && p_ext == CMP_W'(DCID_LEN_POS)) begin
          scid_nxt = SCID_W'(DCID_BASE) + SCID_W'(b);
        end else if (is_long && p_ext >= CMP_W'(DCID_BASE) &&
                     p_ext == CMP_W'(scid_r)) begin
          nfo_nxt   = p_ext + CMP_W'(b) + CMP_W'(SCID_TAIL);
          phase_nxt = PH_SCAN;
        end
      end else begin
        // Varint capture runs on every scanned byte.
        case (cap_r)
          CAP_PREFIX: begin
            case (b[7:6])
              VI_LEN1: begin
                la_nxt  = 30'(b);
                cap_nxt = CAP_IDLE;
              end
              VI_LEN2: begin
                var_nxt = 30'(b[5:0]);
                cap_nxt = 3'd1;
              end
              VI_LEN4: begin
                var_nxt = 30'(b[5:0]);
                cap_nxt = 3'd3;
              end
              default: cap_nxt = CAP_IDLE;
            endcase
          end
          3'd1, 3'd2, 3'd3: begin
            var_nxt = {var_r[21:0], b};
            cap_nxt = cap_r - 3'd1;
            if (cap_r == 3'd1) begin
              la_nxt = {var_r[21:0], b};
            end
          end
          default: cap_nxt = CAP_IDLE;
        endcase

        if (p_ext == nfo_r && (p_ext + CMP_W'(1)) < len_eff) begin
          if (b == FT_ACK || b == FT_ACK_ECN) begin
            if (ack_r != 8'hff) begin
              ack_nxt = ack_r + 8'd1;
            end
            if ((p_ext + CMP_W'(CAPTURE_REACH)) < len_eff) begin
              cap_nxt = CAP_PREFIX;
            end
            nfo_nxt = p_ext + CMP_W'(ACK_SKIP);
          end else if (b == FT_PADDING) begin
            nfo_nxt = p_ext + CMP_W'(1);
          end else begin
            nfo_nxt = p_ext + CMP_W'(OTHER_SKIP);
          end
        end
      end
    end

    if (step && pos_r < MAX_P) begin
      pos_nxt = pos_r + POS_W'(1);
    end

    // Result is taken from the state after this byte.
    ver_ok = (ver_nxt == VERSION_1) || ((ver_nxt & VER_DRAFT_MASK) == VER_DRAFT);
    quic   = (len_eff != '0) && first_nxt[HDR_FIXED_BIT] &&
             (!first_nxt[HDR_LONG_BIT] ||
              (p_ext >= CMP_W'(VER_LAST_POS) && len_eff > CMP_W'(VER_LAST_POS) && ver_ok));

    res.is_quic       = quic;
    res.long_header   = (len_eff != '0) && first_nxt[HDR_LONG_BIT];
    res.ack_frames    = quic ? ack_nxt : 8'd0;
    res.largest_acked = quic ? la_nxt : 30'd0;
    res_vld           = step && item.last_byte;

    if (res_vld) begin
      pos_nxt   = '0;
      nfo_nxt   = '0;
      scid_nxt  = '0;
      phase_nxt = PH_HEADER;
      first_nxt = '0;
      ver_nxt   = '0;
      ack_nxt   = '0;
      la_nxt    = '0;
      var_nxt   = '0;
      cap_nxt   = CAP_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      nfo_r   <= '0;
      scid_r  <= '0;
      phase_r <= PH_HEADER;
      first_r <= '0;
      ver_r   <= '0;
      ack_r   <= '0;
      la_r    <= '0;
      var_r   <= '0;
      cap_r   <= CAP_IDLE;
    end else begin
      pos_r   <= pos_nxt;
      nfo_r   <= nfo_nxt;
      scid_r  <= scid_nxt;
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      ver_r   <= ver_nxt;
      ack_r   <= ack_nxt;
      la_r    <= la_nxt;
      var_r   <= var_nxt;
      cap_r   <= cap_nxt;
    end
  end

  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last_byte |=> pos_r == '0)
    else $error("byte position not cleared after end of packet");

  a_no_ack_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> ack_r == '0)
    else $error("ACK counted before header was skipped");

  a_capture_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r != CAP_IDLE |-> phase_r == PH_SCAN)
    else $error("varint capture active outside frame scan");

endmodule
`default_nettype wire

>>> hw/rtl/qafs_out_stage.sv
// Result register: holds one packet result word until the consumer takes it.
`default_nettype none
module qafs_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_vld,
  input  qafs_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_busy,
  output logic              out_is_quic,
  output logic              out_long_header,
  output logic [7:0]        out_ack_frames,
  output logic [29:0]       out_largest_acked
);
  import qafs_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (res_vld) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

  assign out_busy          = vld_r && out_stall;
  assign out_valid         = vld_r;
  assign out_is_quic       = res_r.is_quic;
  assign out_long_header   = res_r.long_header;
  assign out_ack_frames    = res_r.ack_frames;
  assign out_largest_acked = res_r.largest_acked;

endmodule
`default_nettype wire

>>> hw/rtl/quic_ack_frame_scanner.sv
// QUIC ACK frame scanner, top level.
//
// Takes one UDP payload byte per clock, sustained, with no gaps needed between
// packets. Each byte is registered, then the core logic updates the packet
// state (header check, frame walk, ACK varint capture) and, on the byte marked
// last, loads the result register, which then offers the result word. The
// input side stalls only when a last byte would overwrite a result still held
// by out_stall. MAX_PAYLOAD caps the effective payload length and the byte
// position counter.
`default_nettype none
module quic_ack_frame_scanner #(
  parameter int MAX_PAYLOAD = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [11:0] in_payload_length,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_quic,
  output logic        out_long_header,
  output logic [7:0]  out_ack_frames,
  output logic [29:0] out_largest_acked
);
  import qafs_pkg::*;

  logic    out_busy;
  logic    item_vld;
  logic    step;
  item_t   item;
  logic    res_vld;
  result_t res;

  qafs_in_stage u_in (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_payload_length (in_payload_length),
    .in_last_byte      (in_last_byte),
    .out_busy          (out_busy),
    .item_vld          (item_vld),
    .step              (step),
    .item              (item)
  );

  qafs_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .item    (item),
    .res_vld (res_vld),
    .res     (res)
  );

  qafs_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_vld           (res_vld),
    .res               (res),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_busy          (out_busy),
    .out_is_quic       (out_is_quic),
    .out_long_header   (out_long_header),
    .out_ack_frames    (out_ack_frames),
    .out_largest_acked (out_largest_acked)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(item_vld && item.last_byte))
    else $error("result word without a last byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> !(out_valid && out_stall))
    else $error("result register overwritten while held");

endmodule
`default_nettype wire
